/* sv/bli_pkg.sv */
package bli_pkg;

	// CORDIC depth (valid range 8 to 30)
	localparam int CORDIC_ITERATIONS = 16;
	localparam int ATAN_LEN = 30;
	localparam int COR_STEPS = (CORDIC_ITERATIONS < ATAN_LEN) ? CORDIC_ITERATIONS : ATAN_LEN;

	// datapath widths
	localparam int H_W    = 25;   // heading in [0,360) degrees, Q16.16
	localparam int A_W    = 26;   // folded heading, signed
	localparam int Z_W    = 33;   // CORDIC angle, Q30
	localparam int XY_W   = 33;   // CORDIC vector, Q30
	localparam int C_W    = XY_W - 2; // cosine and sine, Q28
	localparam int D_W    = 33;   // coordinate difference
	localparam int DEN_W  = 34;   // denominator, Q30
	localparam int NUM_W  = 65;   // numerator, Q44
	localparam int NM_W   = 66;   // four times |numerator|
	localparam int DM_W   = 33;   // |denominator|
	localparam int QB     = 35;   // quotient bits
	localparam int REM_W  = DM_W; // partial remainder
	localparam int L_W    = QB + 1; // signed distance along first line
	localparam int SUM_W  = 66;   // projection accumulator
	localparam int P_W    = SUM_W - 28; // projected coordinate before clamping

	// heading reduction: one conditional subtract of 360 * 2^k per stage
	localparam int RED_STEPS = 7;
	localparam logic [31:0] DEG360_W   = 32'd23592960;
	localparam logic [31:0] DEG360_X92 = 32'd2170552320; // brings any negative heading above zero

	localparam logic [H_W-1:0] DEG90  = 25'd5898240;
	localparam logic [H_W-1:0] DEG180 = 25'd11796480;
	localparam logic [H_W-1:0] DEG270 = 25'd17694720;
	localparam logic [H_W-1:0] DEG360 = 25'd23592960;

	localparam logic signed [27:0] RAD_PER_DEG_Q32 = 28'sd74961321;
	localparam logic signed [XY_W-1:0] INV_GAIN_Q30 = 33'sd652032874;
	localparam logic [QB-1:0] L_LIMIT = 35'h4_0000_0000;

	localparam logic [15:0] THR_RESET = 16'd375;

	localparam logic [29:0] ATAN_TAB [ATAN_LEN] = '{
		30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
		30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
		30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535,
		30'd32767, 30'd16383, 30'd8191, 30'd4095, 30'd2047,
		30'd1023, 30'd511, 30'd255, 30'd127, 30'd63,
		30'd31, 30'd15, 30'd7, 30'd3, 30'd1
	};

	typedef enum logic [1:0] {
		ST_VALID     = 2'd0,
		ST_PARALLEL  = 2'd1,
		ST_SATURATED = 2'd2
	} status_t;

	// point data carried down to the cross-product stage
	typedef struct packed {
		logic signed [31:0]    x1;
		logic signed [31:0]    y1;
		logic signed [D_W-1:0] dx;
		logic signed [D_W-1:0] dy;
	} geo_t;

	// data carried from the cross products to the projection
	typedef struct packed {
		logic                  par;
		logic                  neg_l;
		logic signed [31:0]    x1;
		logic signed [31:0]    y1;
		logic signed [C_W-1:0] c1;
		logic signed [C_W-1:0] s1;
	} tail_t;

	// one restoring-divider stage
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QB-1:0]    q;
		logic [QB-1:0]    nlo;
		logic [DM_W-1:0]  d;
		logic             ovf;
		tail_t            t;
	} div_t;

endpackage

/* sv/bearing_line_intersection.sv */
// Crossing point of two lines, each given as a point and a heading in degrees, all signed
// Q16.16. One item enters per clock while the output is not stalled. The pipeline holds 1 input
// stage, 7 heading-reduction stages, 2 angle stages, one CORDIC stage per iteration for both
// headings side by side, 4 cross-product stages, a restoring divider of 36 stages (a load stage,
// then one quotient bit per stage) and 4 projection and output stages.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated. Status 1 marks
// parallel lines (result zero), status 2 a result clamped to range. parallel_threshold is
// written through cfg_wen / cfg_wdata and should only change while the pipeline is empty.
module bearing_line_intersection (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// first_x, first_y, first_heading, second_x, second_y, second_heading
	input  logic [191:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// cross_x, cross_y
	output logic [63:0]  m_tdata,
	// status
	output logic [1:0]   m_tuser,
	input  logic         cfg_wen,
	input  logic [15:0]  cfg_wdata
);

	logic adv;
	logic [15:0] thr_q;

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= bli_pkg::THR_RESET;
		end else if (cfg_wen) begin
			thr_q <= cfg_wdata;
		end
	end

	// ---------------- input stage and heading reduction ----------------
	logic              red_v_s   [bli_pkg::RED_STEPS+1];
	logic [31:0]       red_u_s   [bli_pkg::RED_STEPS+1][2];
	bli_pkg::geo_t     red_geo_s [bli_pkg::RED_STEPS+1];
	logic [31:0]       hin       [2];
	logic [31:0]       hoff      [2];
	bli_pkg::geo_t     geo_in;

	always_comb begin
		logic signed [31:0] x1, y1, x2, y2;
		x1 = s_tdata[31:0];
		y1 = s_tdata[63:32];
		x2 = s_tdata[127:96];
		y2 = s_tdata[159:128];
		hin[0] = s_tdata[95:64];
		hin[1] = s_tdata[191:160];
		for (int l = 0; l < 2; l++) begin
			hoff[l] = hin[l][31] ? hin[l] + bli_pkg::DEG360_X92 : hin[l];
		end
		geo_in.x1 = x1;
		geo_in.y1 = y1;
		geo_in.dx = bli_pkg::D_W'(x2) - bli_pkg::D_W'(x1);
		geo_in.dy = bli_pkg::D_W'(y2) - bli_pkg::D_W'(y1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= bli_pkg::RED_STEPS; j++) red_v_s[j] <= 1'b0;
		end else if (adv) begin
			red_v_s[0] <= s_tvalid;
			for (int j = 0; j < bli_pkg::RED_STEPS; j++) red_v_s[j+1] <= red_v_s[j];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red_geo_s[0] <= geo_in;
			red_u_s[0][0] <= hoff[0];
			red_u_s[0][1] <= hoff[1];
			for (int j = 0; j < bli_pkg::RED_STEPS; j++) begin
				red_geo_s[j+1] <= red_geo_s[j];
				for (int l = 0; l < 2; l++) begin
					if (red_u_s[j][l] >= (bli_pkg::DEG360_W << (bli_pkg::RED_STEPS - 1 - j)))
						red_u_s[j+1][l] <= red_u_s[j][l] -
							(bli_pkg::DEG360_W << (bli_pkg::RED_STEPS - 1 - j));
					else
						red_u_s[j+1][l] <= red_u_s[j][l];
				end
			end
		end
	end

	// ---------------- fold into [-90,90] and parallel test ----------------
	logic                          v_s2;
	logic signed [bli_pkg::A_W-1:0] a_s2 [2];
	logic                          neg_s2 [2];
	logic                          par_s2;
	bli_pkg::geo_t                 geo_s2;
	logic [bli_pkg::H_W-1:0]       h      [2];
	logic signed [bli_pkg::A_W-1:0] a_n   [2];
	logic                          neg_n  [2];
	logic                          par_n;

	always_comb begin
		logic signed [bli_pkg::H_W:0] dd;
		logic [bli_pkg::H_W-1:0] dw, dm;
		for (int l = 0; l < 2; l++) begin
			h[l] = red_u_s[bli_pkg::RED_STEPS][l][bli_pkg::H_W-1:0];
			neg_n[l] = 1'b0;
			if (h[l] > bli_pkg::DEG90 && h[l] < bli_pkg::DEG270) begin
				a_n[l] = $signed({1'b0, h[l]}) - $signed({1'b0, bli_pkg::DEG180});
				neg_n[l] = 1'b1;
			end else if (h[l] >= bli_pkg::DEG270) begin
				a_n[l] = $signed({1'b0, h[l]}) - $signed({1'b0, bli_pkg::DEG360});
			end else begin
				a_n[l] = $signed({1'b0, h[l]});
			end
		end
		// heading difference modulo 180
		dd = $signed({1'b0, h[0]}) - $signed({1'b0, h[1]});
		dw = dd[bli_pkg::H_W] ? bli_pkg::H_W'(dd) + bli_pkg::DEG360 : bli_pkg::H_W'(dd);
		dm = (dw >= bli_pkg::DEG180) ? dw - bli_pkg::DEG180 : dw;
		par_n = (dm < bli_pkg::H_W'(thr_q)) || ((bli_pkg::DEG180 - dm) < bli_pkg::H_W'(thr_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= red_v_s[bli_pkg::RED_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2[0]   <= a_n[0];
			a_s2[1]   <= a_n[1];
			neg_s2[0] <= neg_n[0];
			neg_s2[1] <= neg_n[1];
			par_s2    <= par_n;
			geo_s2    <= red_geo_s[bli_pkg::RED_STEPS];
		end
	end

	// ---------------- radians and CORDIC rotation ----------------
	logic                           cor_v_s   [bli_pkg::COR_STEPS+1];
	logic signed [bli_pkg::XY_W-1:0] cor_x_s  [bli_pkg::COR_STEPS+1][2];
	logic signed [bli_pkg::XY_W-1:0] cor_y_s  [bli_pkg::COR_STEPS+1][2];
	logic signed [bli_pkg::Z_W-1:0]  cor_z_s  [bli_pkg::COR_STEPS+1][2];
	logic                           cor_neg_s [bli_pkg::COR_STEPS+1][2];
	logic                           cor_par_s [bli_pkg::COR_STEPS+1];
	bli_pkg::geo_t                  cor_geo_s [bli_pkg::COR_STEPS+1];
	logic signed [bli_pkg::Z_W-1:0]  z0       [2];
	logic signed [bli_pkg::XY_W-1:0] cor_xn   [bli_pkg::COR_STEPS][2];
	logic signed [bli_pkg::XY_W-1:0] cor_yn   [bli_pkg::COR_STEPS][2];
	logic signed [bli_pkg::Z_W-1:0]  cor_zn   [bli_pkg::COR_STEPS][2];

	// z = round(a * pi/180) in Q30
	always_comb begin
		logic signed [53:0] zp;
		for (int l = 0; l < 2; l++) begin
			zp = 54'(a_s2[l]) * 54'(bli_pkg::RAD_PER_DEG_Q32) + 54'sd131072;
			z0[l] = zp[18+bli_pkg::Z_W-1:18];
		end
	end

	// one micro-rotation per stage
	always_comb begin
		logic signed [bli_pkg::Z_W-1:0] at;
		for (int i = 0; i < bli_pkg::COR_STEPS; i++) begin
			at = $signed({3'b000, bli_pkg::ATAN_TAB[i]});
			for (int l = 0; l < 2; l++) begin
				if (!cor_z_s[i][l][bli_pkg::Z_W-1]) begin
					cor_xn[i][l] = cor_x_s[i][l] - (cor_y_s[i][l] >>> i);
					cor_yn[i][l] = cor_y_s[i][l] + (cor_x_s[i][l] >>> i);
					cor_zn[i][l] = cor_z_s[i][l] - at;
				end else begin
					cor_xn[i][l] = cor_x_s[i][l] + (cor_y_s[i][l] >>> i);
					cor_yn[i][l] = cor_y_s[i][l] - (cor_x_s[i][l] >>> i);
					cor_zn[i][l] = cor_z_s[i][l] + at;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= bli_pkg::COR_STEPS; i++) cor_v_s[i] <= 1'b0;
		end else if (adv) begin
			cor_v_s[0] <= v_s2;
			for (int i = 0; i < bli_pkg::COR_STEPS; i++) cor_v_s[i+1] <= cor_v_s[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cor_par_s[0] <= par_s2;
			cor_geo_s[0] <= geo_s2;
			for (int l = 0; l < 2; l++) begin
				cor_x_s[0][l]   <= bli_pkg::INV_GAIN_Q30;
				cor_y_s[0][l]   <= '0;
				cor_z_s[0][l]   <= z0[l];
				cor_neg_s[0][l] <= neg_s2[l];
			end
			for (int i = 0; i < bli_pkg::COR_STEPS; i++) begin
				cor_par_s[i+1] <= cor_par_s[i];
				cor_geo_s[i+1] <= cor_geo_s[i];
				for (int l = 0; l < 2; l++) begin
					cor_x_s[i+1][l]   <= cor_xn[i][l];
					cor_y_s[i+1][l]   <= cor_yn[i][l];
					cor_z_s[i+1][l]   <= cor_zn[i][l];
					cor_neg_s[i+1][l] <= cor_neg_s[i][l];
				end
			end
		end
	end

	// ---------------- cosine and sine in Q28 ----------------
	logic                           v_s4;
	logic signed [bli_pkg::C_W-1:0]  c_s4 [2];
	logic signed [bli_pkg::C_W-1:0]  s_s4 [2];
	logic                           par_s4;
	bli_pkg::geo_t                  geo_s4;
	logic signed [bli_pkg::C_W-1:0]  c_n  [2];
	logic signed [bli_pkg::C_W-1:0]  s_n  [2];

	always_comb begin
		logic signed [bli_pkg::XY_W-1:0] tx, ty;
		for (int l = 0; l < 2; l++) begin
			tx = cor_x_s[bli_pkg::COR_STEPS][l] + bli_pkg::XY_W'(2);
			ty = cor_y_s[bli_pkg::COR_STEPS][l] + bli_pkg::XY_W'(2);
			c_n[l] = cor_neg_s[bli_pkg::COR_STEPS][l] ? -tx[bli_pkg::XY_W-1:2] : tx[bli_pkg::XY_W-1:2];
			s_n[l] = cor_neg_s[bli_pkg::COR_STEPS][l] ? -ty[bli_pkg::XY_W-1:2] : ty[bli_pkg::XY_W-1:2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= cor_v_s[bli_pkg::COR_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s4[0] <= c_n[0];
			c_s4[1] <= c_n[1];
			s_s4[0] <= s_n[0];
			s_s4[1] <= s_n[1];
			par_s4  <= cor_par_s[bli_pkg::COR_STEPS];
			geo_s4  <= cor_geo_s[bli_pkg::COR_STEPS];
		end
	end

	// ---------------- cross products ----------------
	logic               v_s5;
	logic signed [61:0] pd1_s5, pd2_s5;
	logic signed [63:0] pn1_s5, pn2_s5;
	bli_pkg::tail_t     tail_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pd1_s5 <= 62'(s_s4[0]) * 62'(c_s4[1]);
			pd2_s5 <= 62'(c_s4[0]) * 62'(s_s4[1]);
			pn1_s5 <= 64'(geo_s4.dy) * 64'(c_s4[1]);
			pn2_s5 <= 64'(geo_s4.dx) * 64'(s_s4[1]);
			tail_s5.par   <= par_s4;
			tail_s5.neg_l <= 1'b0;
			tail_s5.x1    <= geo_s4.x1;
			tail_s5.y1    <= geo_s4.y1;
			tail_s5.c1    <= c_s4[0];
			tail_s5.s1    <= s_s4[0];
		end
	end

	// ---------------- numerator and denominator ----------------
	logic                             v_s6;
	logic signed [bli_pkg::DEN_W-1:0] den_s6;
	logic signed [bli_pkg::NUM_W-1:0] num_s6;
	bli_pkg::tail_t                   tail_s6;
	logic signed [62:0]               ddiff;
	logic signed [bli_pkg::DEN_W-1:0] den_n;

	assign ddiff = 63'(pd1_s5) - 63'(pd2_s5);
	assign den_n = ddiff[26+bli_pkg::DEN_W-1:26];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s6  <= den_n;
			num_s6  <= bli_pkg::NUM_W'(pn1_s5) - bli_pkg::NUM_W'(pn2_s5);
			tail_s6.par   <= tail_s5.par || (den_n == '0);
			tail_s6.neg_l <= tail_s5.neg_l;
			tail_s6.x1    <= tail_s5.x1;
			tail_s6.y1    <= tail_s5.y1;
			tail_s6.c1    <= tail_s5.c1;
			tail_s6.s1    <= tail_s5.s1;
		end
	end

	// ---------------- magnitudes and sign ----------------
	logic                            v_s7;
	logic [bli_pkg::NM_W-1:0]        nmag_s7;
	logic [bli_pkg::DM_W-1:0]        dmag_s7;
	bli_pkg::tail_t                  tail_s7;
	logic signed [bli_pkg::NUM_W-1:0] nabs;
	logic signed [bli_pkg::DEN_W-1:0] dabs;

	assign nabs = num_s6[bli_pkg::NUM_W-1] ? -num_s6 : num_s6;
	assign dabs = den_s6[bli_pkg::DEN_W-1] ? -den_s6 : den_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nmag_s7 <= {nabs[bli_pkg::NM_W-3:0], 2'b00};
			dmag_s7 <= dabs[bli_pkg::DM_W-1:0];
			tail_s7.par   <= tail_s6.par;
			tail_s7.neg_l <= num_s6[bli_pkg::NUM_W-1] ^ den_s6[bli_pkg::DEN_W-1];
			tail_s7.x1    <= tail_s6.x1;
			tail_s7.y1    <= tail_s6.y1;
			tail_s7.c1    <= tail_s6.c1;
			tail_s7.s1    <= tail_s6.s1;
		end
	end

	// ---------------- restoring divider, one quotient bit per stage ----------------
	logic          div_v_s [bli_pkg::QB+1];
	bli_pkg::div_t div_s   [bli_pkg::QB+1];
	bli_pkg::div_t div_n   [bli_pkg::QB];
	bli_pkg::div_t div_init;

	// leading part of the dividend; overflow when the quotient needs more than QB bits
	always_comb begin
		div_init.rem = bli_pkg::REM_W'(nmag_s7[bli_pkg::NM_W-1:bli_pkg::QB]);
		div_init.q   = '0;
		div_init.nlo = nmag_s7[bli_pkg::QB-1:0];
		div_init.d   = dmag_s7;
		div_init.ovf = (bli_pkg::DM_W'(nmag_s7[bli_pkg::NM_W-1:bli_pkg::QB]) >= dmag_s7);
		div_init.t   = tail_s7;
	end

	always_comb begin
		logic [bli_pkg::REM_W:0] t;
		for (int j = 0; j < bli_pkg::QB; j++) begin
			div_n[j] = div_s[j];
			t = {div_s[j].rem, div_s[j].nlo[bli_pkg::QB-1-j]};
			if (t >= {1'b0, div_s[j].d}) begin
				t = t - {1'b0, div_s[j].d};
				div_n[j].q = {div_s[j].q[bli_pkg::QB-2:0], 1'b1};
			end else begin
				div_n[j].q = {div_s[j].q[bli_pkg::QB-2:0], 1'b0};
			end
			div_n[j].rem = t[bli_pkg::REM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= bli_pkg::QB; j++) div_v_s[j] <= 1'b0;
		end else if (adv) begin
			div_v_s[0] <= v_s7;
			for (int j = 0; j < bli_pkg::QB; j++) div_v_s[j+1] <= div_v_s[j];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0] <= div_init;
			for (int j = 0; j < bli_pkg::QB; j++) div_s[j+1] <= div_n[j];
		end
	end

	// ---------------- signed, clamped distance ----------------
	logic                           v_s9;
	logic signed [bli_pkg::L_W-1:0] l_s9;
	logic                           sat_s9;
	bli_pkg::tail_t                 tail_s9;
	logic                           over;
	logic [bli_pkg::QB-1:0]         lmag;

	assign over = div_s[bli_pkg::QB].ovf || (div_s[bli_pkg::QB].q > bli_pkg::L_LIMIT);
	assign lmag = over ? bli_pkg::L_LIMIT : div_s[bli_pkg::QB].q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s9 <= div_v_s[bli_pkg::QB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			l_s9    <= div_s[bli_pkg::QB].t.neg_l ? -$signed({1'b0, lmag}) : $signed({1'b0, lmag});
			sat_s9  <= over;
			tail_s9 <= div_s[bli_pkg::QB].t;
		end
	end

	// ---------------- projection: partial products of l * c1 and l * s1 ----------------
	logic               v_s10;
	logic signed [49:0] pxlo_s10, pylo_s10;
	logic signed [48:0] pxhi_s10, pyhi_s10;
	logic               sat_s10, par_s10;
	logic signed [31:0] x1_s10, y1_s10;
	logic signed [18:0] llo;
	logic signed [17:0] lhi;

	assign llo = $signed({1'b0, l_s9[17:0]});
	assign lhi = l_s9[bli_pkg::L_W-1:18];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (adv) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pxlo_s10 <= 50'(llo) * 50'(tail_s9.c1);
			pylo_s10 <= 50'(llo) * 50'(tail_s9.s1);
			pxhi_s10 <= 49'(lhi) * 49'(tail_s9.c1);
			pyhi_s10 <= 49'(lhi) * 49'(tail_s9.s1);
			sat_s10  <= sat_s9;
			par_s10  <= tail_s9.par;
			x1_s10   <= tail_s9.x1;
			y1_s10   <= tail_s9.y1;
		end
	end

	// ---------------- projection: sum and round ----------------
	logic                            v_s11;
	logic signed [bli_pkg::P_W-1:0]  px_s11, py_s11;
	logic                            sat_s11, par_s11;
	logic signed [bli_pkg::SUM_W-1:0] sx, sy;

	assign sx = (bli_pkg::SUM_W'(x1_s10) <<< 28) + (bli_pkg::SUM_W'(pxhi_s10) <<< 18)
		+ bli_pkg::SUM_W'(pxlo_s10) + (bli_pkg::SUM_W'(1) <<< 27);
	assign sy = (bli_pkg::SUM_W'(y1_s10) <<< 28) + (bli_pkg::SUM_W'(pyhi_s10) <<< 18)
		+ bli_pkg::SUM_W'(pylo_s10) + (bli_pkg::SUM_W'(1) <<< 27);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (adv) begin
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s11  <= sx[bli_pkg::SUM_W-1:28];
			py_s11  <= sy[bli_pkg::SUM_W-1:28];
			sat_s11 <= sat_s10;
			par_s11 <= par_s10;
		end
	end

	// ---------------- clamp and output register ----------------
	logic signed [31:0] cx, cy;
	logic               ovx, ovy;

	always_comb begin
		ovx = 1'b1;
		ovy = 1'b1;
		if (px_s11 > bli_pkg::P_W'(32'sh7fff_ffff)) cx = 32'sh7fff_ffff;
		else if (px_s11 < bli_pkg::P_W'(-33'sh8000_0000)) cx = 32'sh8000_0000;
		else begin
			cx = px_s11[31:0];
			ovx = 1'b0;
		end
		if (py_s11 > bli_pkg::P_W'(32'sh7fff_ffff)) cy = 32'sh7fff_ffff;
		else if (py_s11 < bli_pkg::P_W'(-33'sh8000_0000)) cy = 32'sh8000_0000;
		else begin
			cy = py_s11[31:0];
			ovy = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (par_s11) begin
				m_tdata <= '0;
				m_tuser <= bli_pkg::ST_PARALLEL;
			end else begin
				m_tdata <= {cy, cx};
				m_tuser <= (sat_s11 || ovx || ovy) ? bli_pkg::ST_SATURATED : bli_pkg::ST_VALID;
			end
		end
	end

endmodule

/* tb/sv/bearing_line_intersection_tb.sv */
module bearing_line_intersection_tb;

	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic [1:0]         st;
	} cross_t;

	localparam longint H360 = 64'sd23592960;
	localparam longint H180 = 64'sd11796480;
	localparam longint H90  = 64'sd5898240;
	localparam longint H270 = 64'sd17694720;
	localparam longint LLIM = 64'sd17179869184;
	localparam int     TIMEOUT = 3000000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [191:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;
	logic [1:0]   m_tuser;
	logic         cfg_wen = 1'b0;
	logic [15:0]  cfg_wdata = '0;

	cross_t    crossings_due[$];
	logic [15:0] thr_model = bli_pkg::THR_RESET;
	int        errors = 0;
	int        cycles = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        hold_cycles = 0;

	bearing_line_intersection i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// floor division by a power of two
	function automatic longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint mod_pos(longint v, longint m);
		longint r;
		r = v % m;
		return (r < 0) ? r + m : r;
	endfunction

	// cosine and sine of a reduced heading, Q4.28
	task automatic heading_cs(input longint h, output longint c, output longint s);
		longint a, x, y, z, dx, dy;
		bit neg;
		a = h;
		neg = 0;
		x = 64'sd652032874;
		y = 0;
		if (h > H90 && h < H270) begin
			a = h - H180;
			neg = 1;
		end else if (h >= H270) begin
			a = h - H360;
		end
		z = fshift(a * 64'sd74961321 + (64'sd1 << 17), 18);
		for (int i = 0; i < bli_pkg::COR_STEPS; i++) begin
			dx = fshift(y, i);
			dy = fshift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(bli_pkg::ATAN_TAB[i]);
			end else begin
				x += dx; y -= dy; z += longint'(bli_pkg::ATAN_TAB[i]);
			end
		end
		x = fshift(x + 2, 2);
		y = fshift(y + 2, 2);
		c = neg ? -x : x;
		s = neg ? -y : y;
	endtask

	function automatic longint clamp32(longint v, ref bit sat);
		if (v > 64'sd2147483647) begin sat = 1; return 64'sd2147483647; end
		if (v < -64'sd2147483648) begin sat = 1; return -64'sd2147483648; end
		return v;
	endfunction

	// crossing point of the two bearing lines
	task automatic predict_crossing(input logic [191:0] d, output cross_t r);
		longint x1, y1, h1, x2, y2, h2, dd, c1, s1, c2, s2, den, q, rm, l, px, py;
		logic signed [127:0] num;
		bit sat;
		x1 = longint'($signed(d[31:0]));
		y1 = longint'($signed(d[63:32]));
		h1 = mod_pos(longint'($signed(d[95:64])), H360);
		x2 = longint'($signed(d[127:96]));
		y2 = longint'($signed(d[159:128]));
		h2 = mod_pos(longint'($signed(d[191:160])), H360);
		sat = 0;
		dd = mod_pos(h1 - h2, H180);
		heading_cs(h1, c1, s1);
		heading_cs(h2, c2, s2);
		den = fshift(s1 * c2 - c1 * s2, 26);
		if (dd < longint'(thr_model) || H180 - dd < longint'(thr_model) || den == 0) begin
			r = '{0, 0, bli_pkg::ST_PARALLEL};
			return;
		end
		num = 128'(y2 - y1) * 128'(c2) - 128'(x2 - x1) * 128'(s2);
		q = longint'(num / 128'(den));
		rm = longint'(num % 128'(den));
		if (q > LLIM || q < -LLIM) begin
			l = ((num < 0) != (den < 0)) ? -LLIM : LLIM;
			sat = 1;
		end else begin
			l = q * 4 + (rm * 4) / den;
			if (l > LLIM) begin l = LLIM; sat = 1; end
			if (l < -LLIM) begin l = -LLIM; sat = 1; end
		end
		px = fshift(x1 * (64'sd1 << 28) + l * c1 + (64'sd1 << 27), 28);
		py = fshift(y1 * (64'sd1 << 28) + l * s1 + (64'sd1 << 27), 28);
		px = clamp32(px, sat);
		py = clamp32(py, sat);
		r.cx = px[31:0];
		r.cy = py[31:0];
		r.st = sat ? bli_pkg::ST_SATURATED : bli_pkg::ST_VALID;
	endtask

	// send one item, with random idle time before it; valid stays up after the handshake
	task automatic send_pair(input logic [191:0] d);
		cross_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		predict_crossing(d, r);
		crossings_due = {crossings_due, r};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_lines(input longint x1, y1, h1, x2, y2, h2);
		send_pair({h2[31:0], y2[31:0], x2[31:0], h1[31:0], y1[31:0], x1[31:0]});
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(2000000)) - 1000000);
			default: return 32'($signed($urandom_range(200000000)) - 100000000);
		endcase
	endfunction

	function automatic logic [31:0] rand_heading();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($urandom_range(23592959));
			2: return 32'($urandom_range(4) * 5898240 + $urandom_range(800) - 400);
			default: return 32'($signed($urandom_range(47185920)) - 23592960);
		endcase
	endfunction

	// wait for all results and the pipeline to drain, then write the threshold
	task automatic drain_and_set(input logic [15:0] thr);
		s_tvalid <= 1'b0;
		while (crossings_due.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= thr;
		@(negedge clk);
		cfg_wen <= 1'b0;
		thr_model = thr;
	endtask

	task automatic test_directed();
		logic [31:0] mx, mn;
		mx = 32'h7fffffff;
		mn = 32'h80000000;
		send_lines(0, 0, 0, 65536, 0, 90 * 65536);
		send_lines(0, 0, 45 * 65536, 10 * 65536, 0, 135 * 65536);
		send_lines(0, 0, 0, 0, 65536, 0);
		send_lines(0, 0, 0, 0, 65536, 180 * 65536);
		send_lines(0, 0, 10 * 65536, 5, 5, 370 * 65536);
		send_lines(0, 0, 0, 0, 65536, 374);
		send_lines(0, 0, 0, 0, 65536, 375);
		send_lines(0, 0, 0, 0, 65536, H180 - 374);
		send_lines(mx, mx, mx, mn, mn, mn);
		send_lines(mn, mx, 0, mx, mn, 90 * 65536);
		send_lines(mx, 0, 0, mn, 0, 1000);
		send_lines(0, 0, -90 * 65536, 65536, 65536, -1);
		send_lines(0, 0, 270 * 65536, 65536, 0, 360 * 65536 - 1);
		send_lines(mx, mx, 45 * 65536, mn, mx, 135 * 65536);
		send_lines(0, 0, 90 * 65536, 65536, 0, 270 * 65536 + 1000);
		send_lines(-1, -1, 1, 1, 1, 90 * 65536 - 1);
		send_lines(0, 0, 0, 0, mx, 65536);
	endtask

	task automatic test_random(input int n);
		logic [31:0] h1;
		for (int i = 0; i < n; i++) begin
			h1 = rand_heading();
			if ($urandom_range(9) == 0)
				send_pair({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
			else
				send_pair({rand_heading(), rand_coord(), rand_coord(), h1, rand_coord(),
					rand_coord()});
		end
	endtask

	task automatic test_backpressure();
		hold_cycles = 300;
		test_random(150);
	endtask

	// result checker and receiver stalls
	always @(posedge clk) begin
		cross_t w, got;
		cycles <= cycles + 1;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[31:0], m_tdata[63:32], m_tuser};
			if (crossings_due.size() == 0) begin
				$display("%0t unexpected result %h", $time, got);
				errors++;
			end else begin
				w = crossings_due.pop_front();
				if (got.cx !== w.cx)
					$display("%0t cross_x expected %h actual %h", $time, w.cx, got.cx);
				if (got.cy !== w.cy)
					$display("%0t cross_y expected %h actual %h", $time, w.cy, got.cy);
				if (got.st !== w.st)
					$display("%0t status expected %0d actual %0d", $time, w.st, got.st);
				if (got !== w) errors++;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (cycles > TIMEOUT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		drain_and_set(16'd0);
		send_lines(0, 0, 0, 0, 65536, 0);
		send_lines(0, 0, 0, 0, 65536, 180 * 65536);
		test_random(300);
		drain_and_set(16'hffff);
		send_idle_pct = 46;
		test_random(300);
		drain_and_set(16'd375);
		send_idle_pct = 0;
		recv_stall_pct = 46;
		test_random(350);
		drain_and_set(16'(1 + $urandom_range(30000)));
		send_idle_pct = 24;
		recv_stall_pct = 24;
		test_random(350);
		drain_and_set(16'd375);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_backpressure();
		test_random(300);
		s_tvalid <= 1'b0;
		while (crossings_due.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
